/* design/cose_pkg.sv */
// ----------------------------------------------------------------------------
// cose_pkg
// Types, opcodes and power-up constants for the opcode subset executor.
// ----------------------------------------------------------------------------
package cose_pkg;

  typedef struct packed {
    logic [7:0]  op;
    logic [15:0] imm_word;
  } in_t;

  typedef struct packed {
    logic        write_enable;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic        last_result;
    logic        unsupported;
    logic [2:0]  machine_cycles;
    logic [15:0] next_pc;
  } out_t;

  localparam logic [7:0] OP_NOP      = 8'h00;
  localparam logic [7:0] OP_LD_BC_NN = 8'h01;
  localparam logic [7:0] OP_LD_MBC_A = 8'h02;
  localparam logic [7:0] OP_INC_BC   = 8'h03;
  localparam logic [7:0] OP_INC_B    = 8'h04;
  localparam logic [7:0] OP_DEC_B    = 8'h05;
  localparam logic [7:0] OP_LD_B_N   = 8'h06;
  localparam logic [7:0] OP_RLCA     = 8'h07;
  localparam logic [7:0] OP_LD_MNN_SP = 8'h08;
  localparam logic [7:0] OP_ADD_HL_BC = 8'h09;

  localparam logic [7:0]  RESET_A  = 8'h01;
  localparam logic [7:0]  RESET_F  = 8'hB0;
  localparam logic [7:0]  RESET_B  = 8'h00;
  localparam logic [7:0]  RESET_C  = 8'h13;
  localparam logic [7:0]  RESET_H  = 8'h01;
  localparam logic [7:0]  RESET_L  = 8'h4D;
  localparam logic [15:0] RESET_SP = 16'hFFFE;
  localparam logic [15:0] RESET_PC = 16'h0100;

  localparam int unsigned FLAG_Z_BIT = 7;
  localparam int unsigned FLAG_N_BIT = 6;
  localparam int unsigned FLAG_H_BIT = 5;
  localparam int unsigned FLAG_C_BIT = 4;

endpackage

/* design/cpu_opcode_subset_executor.sv */
// ----------------------------------------------------------------------------
// cpu_opcode_subset_executor
// Executes opcodes 0x00 to 0x09 of an 8-bit CPU, one instruction per
// transaction, and reports memory writes, cycle count and next PC.
//
// Usage: each input transaction carries an opcode and the two bytes that
// follow it. The instruction executes in the accepting cycle against the
// architectural registers and its result is registered, so it appears on
// the output channel in the cycle after acceptance. Single-result
// instructions sustain one transaction per cycle while the output is not
// stalled. LD (n16),SP produces two output transactions; the second waits
// in a holding register, and input is not taken until it has moved to the
// output register. A stall on the output holds the shown result; a new
// input is still accepted in the cycle the shown result is taken. Reset
// loads the power-up register values (PC 0x0100) and empties the output
// path; SP is the constant 0xFFFE.
// ----------------------------------------------------------------------------
module cpu_opcode_subset_executor (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cose_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output cose_pkg::out_t out_data_o
);

  logic [7:0]  a_q, a_d, f_q, f_d, b_q, b_d, c_q, c_d, h_q, h_d, l_q, l_d;
  logic [15:0] pc_q, pc_d;

  logic           out_valid_q;
  cose_pkg::out_t out_q;
  logic           pend_valid_q;
  cose_pkg::out_t pend_q;

  cose_pkg::out_t res0, res1;
  logic           two_res;
  logic [1:0]     len;
  logic [7:0]     b_inc, b_dec;
  logic [15:0]    bc_inc;
  logic [16:0]    hl_sum;
  logic [12:0]    hl_low;
  logic           in_acc, out_acc;

  assign out_acc    = out_valid_q && out_ready_i;
  assign in_ready_o = (!out_valid_q || out_ready_i) && !pend_valid_q;
  assign in_acc     = in_valid_i && in_ready_o;

  assign b_inc  = b_q + 8'd1;
  assign b_dec  = b_q - 8'd1;
  assign bc_inc = {b_q, c_q} + 16'd1;
  assign hl_sum = {1'b0, h_q, l_q} + {1'b0, b_q, c_q};
  assign hl_low = {1'b0, h_q[3:0], l_q} + {1'b0, b_q[3:0], c_q};

  always_comb begin
    a_d = a_q; f_d = f_q; b_d = b_q; c_d = c_q; h_d = h_q; l_d = l_q;
    len = 2'd1;
    two_res = 1'b0;
    res0 = '0;
    res0.last_result = 1'b1;
    res0.machine_cycles = 3'd1;
    unique case (in_data_i.op)
      cose_pkg::OP_NOP: begin
      end
      cose_pkg::OP_LD_BC_NN: begin
        b_d = in_data_i.imm_word[15:8];
        c_d = in_data_i.imm_word[7:0];
        len = 2'd3;
        res0.machine_cycles = 3'd3;
      end
      cose_pkg::OP_LD_MBC_A: begin
        res0.write_enable  = 1'b1;
        res0.write_address = {b_q, c_q};
        res0.write_data    = a_q;
        res0.machine_cycles = 3'd2;
      end
      cose_pkg::OP_INC_BC: begin
        b_d = bc_inc[15:8];
        c_d = bc_inc[7:0];
        res0.machine_cycles = 3'd2;
      end
      cose_pkg::OP_INC_B: begin
        b_d = b_inc;
        f_d[cose_pkg::FLAG_Z_BIT] = (b_inc == 8'h00);
        f_d[cose_pkg::FLAG_N_BIT] = 1'b0;
        f_d[cose_pkg::FLAG_H_BIT] = (b_q[3:0] == 4'hF);
      end
      cose_pkg::OP_DEC_B: begin
        b_d = b_dec;
        f_d[cose_pkg::FLAG_Z_BIT] = (b_dec == 8'h00);
        f_d[cose_pkg::FLAG_N_BIT] = 1'b1;
        f_d[cose_pkg::FLAG_H_BIT] = (b_q[3:0] == 4'h0);
      end
      cose_pkg::OP_LD_B_N: begin
        b_d = in_data_i.imm_word[7:0];
        len = 2'd2;
        res0.machine_cycles = 3'd2;
      end
      cose_pkg::OP_RLCA: begin
        a_d = {a_q[6:0], a_q[7]};
        f_d = {3'b000, a_q[7], 4'h0};
      end
      cose_pkg::OP_LD_MNN_SP: begin
        two_res = 1'b1;
        len = 2'd3;
        res0.write_enable   = 1'b1;
        res0.write_address  = in_data_i.imm_word;
        res0.write_data     = cose_pkg::RESET_SP[7:0];
        res0.last_result    = 1'b0;
        res0.machine_cycles = 3'd5;
      end
      cose_pkg::OP_ADD_HL_BC: begin
        h_d = hl_sum[15:8];
        l_d = hl_sum[7:0];
        f_d[cose_pkg::FLAG_N_BIT] = 1'b0;
        f_d[cose_pkg::FLAG_H_BIT] = hl_low[12];
        f_d[cose_pkg::FLAG_C_BIT] = hl_sum[16];
        res0.machine_cycles = 3'd2;
      end
      default: begin
        res0.unsupported = 1'b1;
      end
    endcase
    pc_d = pc_q + {14'd0, len};
    res0.next_pc = pc_d;
    res1 = res0;
    res1.write_address = in_data_i.imm_word + 16'd1;
    res1.write_data    = cose_pkg::RESET_SP[15:8];
    res1.last_result   = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q  <= cose_pkg::RESET_A;
      f_q  <= cose_pkg::RESET_F;
      b_q  <= cose_pkg::RESET_B;
      c_q  <= cose_pkg::RESET_C;
      h_q  <= cose_pkg::RESET_H;
      l_q  <= cose_pkg::RESET_L;
      pc_q <= cose_pkg::RESET_PC;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        a_q  <= a_d;
        f_q  <= f_d;
        b_q  <= b_d;
        c_q  <= c_d;
        h_q  <= h_d;
        l_q  <= l_d;
        pc_q <= pc_d;
        out_valid_q  <= 1'b1;
        pend_valid_q <= two_res;
      end else if (out_acc) begin
        out_valid_q  <= pend_valid_q;
        pend_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q  <= res0;
      pend_q <= res1;
    end else if (out_acc && pend_valid_q) begin
      out_q <= pend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* design/cose_checker.sv */
// ----------------------------------------------------------------------------
// cose_checker
// Port-level checks for the opcode subset executor, bound to cpu_opcode_subset_executor.
// ----------------------------------------------------------------------------
module cose_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input cose_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input cose_pkg::out_t out_data_o
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last_result
    |=> out_valid_o && out_data_o.last_result && out_data_o.write_enable &&
        out_data_o.write_address == $past(out_data_o.write_address) + 16'd1)
    else $error("second SP write transaction missing or misaddressed");

  a_no_input_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_result |-> !in_ready_o)
    else $error("input taken while an instruction is part delivered");

  a_unsup_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.unsupported
    |-> !out_data_o.write_enable && out_data_o.last_result &&
        out_data_o.machine_cycles == 3'd1)
    else $error("unsupported opcode produced side effects");

endmodule

bind cpu_opcode_subset_executor cose_checker u_cose_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for cpu_opcode_subset_executor. A scoreboard predicts
// the architectural registers and the result transactions of each accepted
// instruction, then compares every output transaction field by field, in
// order. The run has a directed table, then random instructions under three
// idling mixes and an output hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import cose_pkg::*;

  localparam logic [7:0]  OP_FIRST_UNUSED = OP_ADD_HL_BC + 8'd1;
  localparam logic [7:0]  OP_CB_PREFIX    = 8'hCB;
  localparam logic [7:0]  OP_TOP_UNUSED   = 8'hFF;
  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned HOLDOFF_CYCLES  = 300;
  localparam int unsigned ROW_COUNT       = 25;

  typedef struct packed {
    in_t  ins;
    logic typed;
    out_t want;
  } dir_row_t;

  // rows with a typed result run from the power-up state; the rest use the predictor
  localparam dir_row_t DIR_ROWS [ROW_COUNT] = '{
    '{'{OP_NOP,          16'h0000}, 1'b1, '{1'b0, 16'h0000, 8'h00, 1'b1, 1'b0, 3'd1, 16'h0101}},
    '{'{OP_CB_PREFIX,    16'hFFFF}, 1'b1, '{1'b0, 16'h0000, 8'h00, 1'b1, 1'b1, 3'd1, 16'h0102}},
    '{'{OP_TOP_UNUSED,   16'h0000}, 1'b1, '{1'b0, 16'h0000, 8'h00, 1'b1, 1'b1, 3'd1, 16'h0103}},
    '{'{OP_FIRST_UNUSED, 16'h5A5A}, 1'b1, '{1'b0, 16'h0000, 8'h00, 1'b1, 1'b1, 3'd1, 16'h0104}},
    '{'{OP_LD_MBC_A,     16'h0000}, 1'b1, '{1'b1, 16'h0013, 8'h01, 1'b1, 1'b0, 3'd2, 16'h0105}},
    '{'{OP_LD_BC_NN,     16'hFFFF}, 1'b1, '{1'b0, 16'h0000, 8'h00, 1'b1, 1'b0, 3'd3, 16'h0108}},
    '{'{OP_INC_BC,       16'h1234}, 1'b1, '{1'b0, 16'h0000, 8'h00, 1'b1, 1'b0, 3'd2, 16'h0109}},
    '{'{OP_LD_MBC_A,     16'hFFFF}, 1'b1, '{1'b1, 16'h0000, 8'h01, 1'b1, 1'b0, 3'd2, 16'h010A}},
    '{'{OP_DEC_B,        16'h0000}, 1'b1, '{1'b0, 16'h0000, 8'h00, 1'b1, 1'b0, 3'd1, 16'h010B}},
    '{'{OP_INC_B,        16'hFFFF}, 1'b1, '{1'b0, 16'h0000, 8'h00, 1'b1, 1'b0, 3'd1, 16'h010C}},
    '{'{OP_LD_B_N,       16'hAB0F}, 1'b1, '{1'b0, 16'h0000, 8'h00, 1'b1, 1'b0, 3'd2, 16'h010E}},
    '{'{OP_INC_B,        16'h0000}, 1'b0, '0},
    '{'{OP_DEC_B,        16'h0000}, 1'b0, '0},
    '{'{OP_RLCA,         16'h0000}, 1'b0, '0},
    '{'{OP_LD_MNN_SP,    16'hFFFF}, 1'b0, '0},
    '{'{OP_LD_MNN_SP,    16'h0000}, 1'b0, '0},
    '{'{OP_LD_BC_NN,     16'hFEB3}, 1'b0, '0},
    '{'{OP_ADD_HL_BC,    16'h0000}, 1'b0, '0},
    '{'{OP_ADD_HL_BC,    16'hFFFF}, 1'b0, '0},
    '{'{OP_LD_MBC_A,     16'h0000}, 1'b0, '0},
    '{'{OP_LD_B_N,       16'h00FF}, 1'b0, '0},
    '{'{OP_INC_BC,       16'h0000}, 1'b0, '0},
    '{'{OP_RLCA,         16'h0000}, 1'b0, '0},
    '{'{OP_CB_PREFIX,    16'h0000}, 1'b0, '0},
    '{'{OP_LD_MBC_A,     16'h0000}, 1'b0, '0}
  };

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  // travels alongside in_data: a typed result for directed rows
  logic in_typed;
  out_t in_want;

  logic [7:0]  cpu_a, cpu_f, cpu_b, cpu_c, cpu_h, cpu_l;
  logic [15:0] cpu_sp, cpu_pc;

  out_t pending_results_q [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned holdoff_len;
  int unsigned idle_run;
  int unsigned error_count;
  int unsigned instr_count;
  int unsigned unsup_count;
  int unsigned result_count;
  int unsigned write_count;

  cpu_opcode_subset_executor i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_error(input string msg);
    if (error_count < 30) begin
      $display("%s", msg);
    end
    error_count++;
  endtask

  task automatic execute_instr(input in_t ins);
    out_t        res;
    logic [7:0]  prev;
    logic [16:0] wide;
    logic [12:0] low12;
    logic [1:0]  len;
    res = '0;
    res.last_result = 1'b1;
    res.machine_cycles = 3'd1;
    len = 2'd1;
    case (ins.op)
      OP_NOP: begin
      end
      OP_LD_BC_NN: begin
        {cpu_b, cpu_c} = ins.imm_word;
        len = 2'd3;
        res.machine_cycles = 3'd3;
      end
      OP_LD_MBC_A: begin
        res.write_enable = 1'b1;
        res.write_address = {cpu_b, cpu_c};
        res.write_data = cpu_a;
        res.machine_cycles = 3'd2;
      end
      OP_INC_BC: begin
        {cpu_b, cpu_c} = {cpu_b, cpu_c} + 16'd1;
        res.machine_cycles = 3'd2;
      end
      OP_INC_B: begin
        prev = cpu_b;
        cpu_b = prev + 8'd1;
        cpu_f[FLAG_Z_BIT] = (cpu_b == 8'd0);
        cpu_f[FLAG_N_BIT] = 1'b0;
        cpu_f[FLAG_H_BIT] = (prev[3:0] == 4'hF);
      end
      OP_DEC_B: begin
        prev = cpu_b;
        cpu_b = prev - 8'd1;
        cpu_f[FLAG_Z_BIT] = (cpu_b == 8'd0);
        cpu_f[FLAG_N_BIT] = 1'b1;
        cpu_f[FLAG_H_BIT] = (prev[3:0] == 4'h0);
      end
      OP_LD_B_N: begin
        cpu_b = ins.imm_word[7:0];
        len = 2'd2;
        res.machine_cycles = 3'd2;
      end
      OP_RLCA: begin
        prev = cpu_a;
        cpu_a = {prev[6:0], prev[7]};
        cpu_f[FLAG_Z_BIT] = 1'b0;
        cpu_f[FLAG_N_BIT] = 1'b0;
        cpu_f[FLAG_H_BIT] = 1'b0;
        cpu_f[FLAG_C_BIT] = prev[7];
      end
      OP_LD_MNN_SP: begin
        res.write_enable = 1'b1;
        res.write_address = ins.imm_word;
        res.write_data = cpu_sp[7:0];
        res.last_result = 1'b0;
        res.machine_cycles = 3'd5;
        len = 2'd3;
      end
      OP_ADD_HL_BC: begin
        low12 = {1'b0, cpu_h[3:0], cpu_l} + {1'b0, cpu_b[3:0], cpu_c};
        wide = {1'b0, cpu_h, cpu_l} + {1'b0, cpu_b, cpu_c};
        cpu_f[FLAG_N_BIT] = 1'b0;
        cpu_f[FLAG_H_BIT] = low12[12];
        cpu_f[FLAG_C_BIT] = wide[16];
        {cpu_h, cpu_l} = wide[15:0];
        res.machine_cycles = 3'd2;
      end
      default: begin
        res.unsupported = 1'b1;
        unsup_count++;
      end
    endcase
    wide = {1'b0, cpu_pc} + 17'(len);
    cpu_pc = wide[15:0];
    res.next_pc = cpu_pc;
    pending_results_q.push_back(res);
    if (ins.op == OP_LD_MNN_SP) begin
      res.write_address = ins.imm_word + 16'd1;
      res.write_data = cpu_sp[15:8];
      res.last_result = 1'b1;
      pending_results_q.push_back(res);
    end
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (pending_results_q.size() == 0) begin
      report_error($sformatf("unexpected result transaction, next_pc 0x%04h", got.next_pc));
      return;
    end
    want = pending_results_q.pop_front();
    if (got.write_enable !== want.write_enable)
      report_error($sformatf("result %0d write_enable: got %0b want %0b",
                             result_count, got.write_enable, want.write_enable));
    if (got.write_address !== want.write_address)
      report_error($sformatf("result %0d write_address: got 0x%04h want 0x%04h",
                             result_count, got.write_address, want.write_address));
    if (got.write_data !== want.write_data)
      report_error($sformatf("result %0d write_data: got 0x%02h want 0x%02h",
                             result_count, got.write_data, want.write_data));
    if (got.last_result !== want.last_result)
      report_error($sformatf("result %0d last_result: got %0b want %0b",
                             result_count, got.last_result, want.last_result));
    if (got.unsupported !== want.unsupported)
      report_error($sformatf("result %0d unsupported: got %0b want %0b",
                             result_count, got.unsupported, want.unsupported));
    if (got.machine_cycles !== want.machine_cycles)
      report_error($sformatf("result %0d machine_cycles: got %0d want %0d",
                             result_count, got.machine_cycles, want.machine_cycles));
    if (got.next_pc !== want.next_pc)
      report_error($sformatf("result %0d next_pc: got 0x%04h want 0x%04h",
                             result_count, got.next_pc, want.next_pc));
  endtask

  // pre-edge values are sampled; prediction runs before checking in the same step
  always @(posedge clk) begin : scoreboard
    if (rst_n) begin
      if (in_valid && in_ready) begin
        execute_instr(in_data);
        if (in_typed) begin
          void'(pending_results_q.pop_back());
          pending_results_q.push_back(in_want);
        end
        instr_count++;
      end
      if (out_valid && out_ready) begin
        check_result(out_data);
        if (out_data.write_enable) begin
          write_count++;
        end
        result_count++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_run = 0;
      end else begin
        idle_run++;
      end
    end
  end

  initial begin : watchdog
    while (idle_run < STALL_LIMIT) begin
      @(posedge clk);
    end
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("testbench: errors");
    $finish;
  end

  initial begin : receiver
    int unsigned n;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_len != 0) begin
        n = holdoff_len;
        holdoff_len = 0;
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [15:0] rand_imm();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  function automatic in_t rand_instr();
    in_t ins;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 85) begin
      ins.op = 8'($urandom_range(int'(OP_ADD_HL_BC), int'(OP_NOP)));
    end else if (pick < 90) begin
      ins.op = OP_CB_PREFIX;
    end else begin
      ins.op = 8'($urandom_range(int'(OP_TOP_UNUSED), int'(OP_FIRST_UNUSED)));
    end
    ins.imm_word = rand_imm();
    return ins;
  endfunction

  // in_ready is taken at the edge itself, before the edge's register updates
  task automatic offer_instr(input in_t ins, input logic typed, input out_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ins;
    in_typed <= typed;
    in_want  <= want;
    @(posedge clk iff in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending_results_q.size() != 0);
  endtask

  task automatic run_random(input int unsigned count, input int unsigned holdoff_at);
    for (int unsigned k = 0; k < count; k++) begin
      if (k == holdoff_at) begin
        holdoff_len = HOLDOFF_CYCLES;
      end
      offer_instr(rand_instr(), 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    in_typed = 1'b0;
    in_want = '0;
    holdoff_len = 0;
    idle_run = 0;
    error_count = 0;
    instr_count = 0;
    unsup_count = 0;
    result_count = 0;
    write_count = 0;
    send_idle_pct = 26;
    recv_idle_pct = 70;
    cpu_a = RESET_A;
    cpu_f = RESET_F;
    cpu_b = RESET_B;
    cpu_c = RESET_C;
    cpu_h = RESET_H;
    cpu_l = RESET_L;
    cpu_sp = RESET_SP;
    cpu_pc = RESET_PC;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int unsigned r = 0; r < ROW_COUNT; r++) begin
      offer_instr(DIR_ROWS[r].ins, DIR_ROWS[r].typed, DIR_ROWS[r].want);
    end
    drain_results();

    // output held off mid-phase while instructions keep coming
    run_random(210, 100);
    drain_results();

    send_idle_pct = 70;
    recv_idle_pct = 26;
    run_random(210, ~0);
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(245, ~0);
    drain_results();

    repeat (10) @(posedge clk);
    $display("covered %0d instructions (%0d unsupported), %0d result transactions,",
             instr_count, unsup_count, result_count);
    $display("  %0d memory writes, three idling mixes, one long output hold-off",
             write_count);
    if (error_count == 0 && pending_results_q.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
